// ===== rtl/bdr_pkg.sv =====
// package for the bayer demosaic block: shared types and constants
// no dependencies
`default_nettype none

package bdr_pkg;

   localparam int LINE_WIDTH_BITS = 13;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int PIXEL_BITS      = 8;
   localparam int RGB_BITS        = 24;
   localparam int MIN_LINE_WIDTH  = 2;
   localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = LINE_WIDTH_BITS'(640);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEMOSAIC_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PACK_RGB565     = 2'd2;

   // per-item site info from the column/row tracker
   typedef struct packed {
      logic emit;     // item yields a result
      logic last;     // last column of the input row
      logic grey;     // replicate mode
      logic sy;       // row parity of window top-left
      logic sx;       // column parity of window top-left
   } site_type;

endpackage

`default_nettype wire

// ===== rtl/bdr_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// read returns the old contents when read and write hit the same address
`default_nettype none

module bdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bdr_ctrl.sv =====
// column and row tracker: line store address and window parity per item
// depends on bdr_pkg
`default_nettype none

module bdr_ctrl
   import bdr_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic                              frame_start,
   input  wire logic [LINE_WIDTH_BITS-1:0]        line_width,
   input  wire logic                              demosaic_enable,
   output logic      [$clog2(MAX_LINE_WIDTH)-1:0] column,
   output site_type                               site
);

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int WW = (CW + 1 > LINE_WIDTH_BITS) ? CW + 1 : LINE_WIDTH_BITS;

   logic [CW-1:0] column_ff, column_in;
   logic          parity_ff, parity_in;
   logic          past_first_ff, past_first_in;

   logic [WW-1:0] lw_ext, w_eff, x_plus;
   logic          parity_cur, past_first_cur, last;

   always_comb begin
      lw_ext = WW'(line_width);
      if (lw_ext < WW'(MIN_LINE_WIDTH)) begin
         w_eff = WW'(MIN_LINE_WIDTH);
      end else if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
         w_eff = WW'(MAX_LINE_WIDTH);
      end else begin
         w_eff = lw_ext;
      end

      column         = frame_start ? '0 : column_ff;
      parity_cur     = frame_start ? 1'b0 : parity_ff;
      past_first_cur = frame_start ? 1'b0 : past_first_ff;

      x_plus = WW'(column) + WW'(1);
      last   = (x_plus >= w_eff);

      site.last = last;
      site.grey = ~demosaic_enable;
      site.sy   = ~parity_cur;
      site.sx   = ~column[0];
      site.emit = ~demosaic_enable | (past_first_cur & (column != '0));

      if (last) begin
         column_in     = '0;
         parity_in     = ~parity_cur;
         past_first_in = 1'b1;
      end else begin
         column_in     = x_plus[CW-1:0];
         parity_in     = parity_cur;
         past_first_in = past_first_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         parity_ff     <= 1'b0;
         past_first_ff <= 1'b0;
      end else if (accept) begin
         column_ff     <= column_in;
         parity_ff     <= parity_in;
         past_first_ff <= past_first_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bdr_color.sv =====
// window color selection, green average and rgb888/rgb565 packing
// depends on bdr_pkg
`default_nettype none

module bdr_color
   import bdr_pkg::*;
(
   input  wire logic [PIXEL_BITS-1:0] top_left,
   input  wire logic [PIXEL_BITS-1:0] top_right,
   input  wire logic [PIXEL_BITS-1:0] bottom_left,
   input  wire logic [PIXEL_BITS-1:0] bottom_right,
   input  wire site_type              site,
   input  wire logic                  pack_rgb565,
   output logic      [RGB_BITS-1:0]   pixel_value
);

   logic [PIXEL_BITS:0]   sum_diag, sum_anti;
   logic [PIXEL_BITS-1:0] red, green, blue;

   always_comb begin
      sum_diag = {1'b0, top_right} + {1'b0, bottom_left};
      sum_anti = {1'b0, top_left} + {1'b0, bottom_right};
      case ({site.sy, site.sx})
         2'b00: begin
            red   = top_left;
            green = sum_diag[PIXEL_BITS:1];
            blue  = bottom_right;
         end
         2'b01: begin
            red   = top_right;
            green = sum_anti[PIXEL_BITS:1];
            blue  = bottom_left;
         end
         2'b10: begin
            red   = bottom_left;
            green = sum_anti[PIXEL_BITS:1];
            blue  = top_right;
         end
         default: begin
            red   = bottom_right;
            green = sum_diag[PIXEL_BITS:1];
            blue  = top_left;
         end
      endcase
      if (site.grey) begin
         red   = bottom_right;
         green = bottom_right;
         blue  = bottom_right;
      end
      if (pack_rgb565) begin
         pixel_value = {8'h00, red[7:3], green[7:2], blue[7:3]};
      end else begin
         pixel_value = {red, green, blue};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bayer_demosaic_to_rgb.sv =====
// bayer rggb to rgb converter, top level; depends on bdr_pkg, bdr_ram,
// bdr_ctrl and bdr_color.
// usage: 8-bit samples enter on req_ (valid/ready) in raster order with
// req_frame_start on the first sample of a frame. results leave on rsp_
// (valid/ready): rsp_pixel_value as rgb888 or rgb565 in the low 16 bits,
// rsp_row_end on the last result of an output row. in demosaic mode the
// first row and first column of each frame give no result; in grey mode
// every item gives one. registers (csr_write_enable, csr_index,
// csr_write_data): 0 line width, 1 demosaic enable, 1 bit, 2 rgb565 pack.
// change them only while idle.
// path: a taken item is held in the stage register, then in the result register.
// throughput: one item per cycle; the line store is read and written once
// per item at the same address, so its single port pair sets the pace.
// a stalled receiver holds the result register; one more item waits in the
// stage register, then req_ready drops.
// reset: counters cleared, registers to 640 / demosaic / rgb888; the line
// store is not cleared and is only valid where the previous row wrote it.
`default_nettype none

module bayer_demosaic_to_rgb
   import bdr_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [PIXEL_BITS-1:0]      req_raw_pixel,
   input  wire logic                       req_frame_start,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [RGB_BITS-1:0]        rsp_pixel_value,
   output logic                            rsp_row_end,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [LINE_WIDTH_BITS-1:0] csr_write_data
);

   localparam int CW = $clog2(MAX_LINE_WIDTH);

   logic [LINE_WIDTH_BITS-1:0] line_width_ff;
   logic                       demosaic_ff, pack_ff;

   logic                  accept, stage_leave;
   logic [CW-1:0]         column;
   site_type              site;
   logic [PIXEL_BITS-1:0] up_pixel;

   logic                  stage_valid_ff, stage_valid_in;
   site_type              stage_site_ff;
   logic [PIXEL_BITS-1:0] stage_pixel_ff;
   logic [PIXEL_BITS-1:0] left_cur_ff, left_prev_ff;

   logic [RGB_BITS-1:0]   pixel_value;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RGB_BITS-1:0]   rsp_pixel_ff;
   logic                  rsp_row_end_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         demosaic_ff   <= 1'b1;
         pack_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:      line_width_ff <= csr_write_data;
            CSR_DEMOSAIC_ENABLE: demosaic_ff   <= csr_write_data[0];
            CSR_PACK_RGB565:     pack_ff       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign stage_leave = stage_valid_ff & (~stage_site_ff.emit | ~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~stage_valid_ff | stage_leave;
   assign accept      = req_valid & req_ready;

   bdr_ctrl #(
      .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .frame_start    (req_frame_start),
      .line_width     (line_width_ff),
      .demosaic_enable(demosaic_ff),
      .column         (column),
      .site           (site)
   );

   bdr_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_LINE_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(column),
      .wr_data(req_raw_pixel),
      .rd_en  (accept),
      .rd_addr(column),
      .rd_data(up_pixel)
   );

   // stage register
   assign stage_valid_in = accept | (stage_valid_ff & ~stage_leave);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_site_ff  <= site;
         stage_pixel_ff <= req_raw_pixel;
      end
   end

   // left neighbors of the window
   always_ff @(posedge clock) begin
      if (reset) begin
         left_cur_ff  <= '0;
         left_prev_ff <= '0;
      end else if (stage_leave) begin
         left_cur_ff  <= stage_pixel_ff;
         left_prev_ff <= up_pixel;
      end
   end

   bdr_color u_color (
      .top_left    (left_prev_ff),
      .top_right   (up_pixel),
      .bottom_left (left_cur_ff),
      .bottom_right(stage_pixel_ff),
      .site        (stage_site_ff),
      .pack_rgb565 (pack_ff),
      .pixel_value (pixel_value)
   );

   // result register
   always_comb begin
      if (stage_leave & stage_site_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_leave & stage_site_ff.emit) begin
         rsp_pixel_ff   <= pixel_value;
         rsp_row_end_ff <= stage_site_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_row_end     = rsp_row_end_ff;

endmodule

`default_nettype wire

// ===== tb/tb_bayer_demosaic_to_rgb.sv =====
// testbench for bayer_demosaic_to_rgb: random and directed pixel streams checked
// against a cycle-free predictor of the rggb demosaic and grey paths
// depends on bdr_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_bayer_demosaic_to_rgb;
   import bdr_pkg::*;

   localparam int MAX_W       = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;
   localparam int FILL_W      = 64;

   typedef struct packed {
      logic [RGB_BITS-1:0] pixel;
      logic                row_end;
   } rgb_result_type;

   class demosaic_predictor;
      logic [PIXEL_BITS-1:0]      row_store [MAX_W];
      logic [PIXEL_BITS-1:0]      left_now;
      logic [PIXEL_BITS-1:0]      left_above;
      int unsigned                column;
      logic                       odd_row;
      logic                       past_first;
      logic [LINE_WIDTH_BITS-1:0] width_reg;
      logic                       demosaic_on;
      logic                       pack_565;
      rgb_result_type             expected_pixels [$];
      int                         errors;

      function new();
         foreach (row_store[i]) row_store[i] = '0;
         left_now    = '0;
         left_above  = '0;
         column      = 0;
         odd_row     = 1'b0;
         past_first  = 1'b0;
         width_reg   = LINE_WIDTH_RESET;
         demosaic_on = 1'b1;
         pack_565    = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx,
                              logic [LINE_WIDTH_BITS-1:0] value);
         case (idx)
            CSR_LINE_WIDTH: begin
               width_reg = value;
            end
            CSR_DEMOSAIC_ENABLE: begin
               demosaic_on = value[0];
            end
            CSR_PACK_RGB565: begin
               pack_565 = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [RGB_BITS-1:0] pack(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         if (pack_565) return {8'h00, r[7:3], g[7:2], b[7:3]};
         return {r, g, b};
      endfunction

      function logic [7:0] mean2(logic [7:0] a, logic [7:0] b);
         logic [8:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[8:1];
      endfunction

      function void take_sample(logic [PIXEL_BITS-1:0] p, logic frame_start);
         int unsigned     w;
         int unsigned     x;
         logic [7:0]      up;
         logic [7:0]      r;
         logic [7:0]      g;
         logic [7:0]      b;
         logic            last;
         logic            sy;
         logic            sx;
         if (frame_start) begin
            column     = 0;
            odd_row    = 1'b0;
            past_first = 1'b0;
         end
         w = width_reg;
         if (w < MIN_LINE_WIDTH) w = MIN_LINE_WIDTH;
         if (w > MAX_W) w = MAX_W;
         x = (column >= MAX_W) ? MAX_W - 1 : column;
         last = (x + 1 >= w);
         up = row_store[x];
         if (!demosaic_on) begin
            expected_pixels.push_back('{pixel: pack(p, p, p), row_end: last});
         end else if (past_first && x >= 1) begin
            // parity of the window's top-left site
            sy = ~odd_row;
            sx = ((x - 1) % 2) == 1;
            case ({sy, sx})
               2'b00: begin
                  r = left_above; g = mean2(up, left_now); b = p;
               end
               2'b01: begin
                  r = up; g = mean2(left_above, p); b = left_now;
               end
               2'b10: begin
                  r = left_now; g = mean2(left_above, p); b = up;
               end
               default: begin
                  r = p; g = mean2(up, left_now); b = left_above;
               end
            endcase
            expected_pixels.push_back('{pixel: pack(r, g, b), row_end: last});
         end
         left_above   = up;
         left_now     = p;
         row_store[x] = p;
         if (last) begin
            column     = 0;
            odd_row    = ~odd_row;
            past_first = 1'b1;
         end else begin
            column = x + 1;
         end
      endfunction

      task report_mismatch(string what, logic [RGB_BITS-1:0] got,
                           logic [RGB_BITS-1:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      endtask

      task check_pixel(logic [RGB_BITS-1:0] pixel, logic row_end);
         rgb_result_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected item", pixel, '0);
            return;
         end
         want = expected_pixels.pop_front();
         if (pixel !== want.pixel) report_mismatch("pixel_value", pixel, want.pixel);
         if (row_end !== want.row_end) report_mismatch("row_end", row_end, want.row_end);
      endtask

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [PIXEL_BITS-1:0]      req_raw_pixel    = '0;
   logic                       req_frame_start  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [RGB_BITS-1:0]        rsp_pixel_value;
   logic                       rsp_row_end;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index        = '0;
   logic [LINE_WIDTH_BITS-1:0] csr_write_data   = '0;
   logic                       steady           = 1'b0;
   int                         cycles;

   demosaic_predictor model = new();

   bayer_demosaic_to_rgb #(
      .MAX_LINE_WIDTH(MAX_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_raw_pixel(req_raw_pixel),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_row_end(rsp_row_end),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) model.check_pixel(rsp_pixel_value, rsp_row_end);
         if (req_valid && req_ready) model.take_sample(req_raw_pixel, req_frame_start);
      end
   end

   task automatic send_sample(input logic [PIXEL_BITS-1:0] pix, input logic frame_start);
      if (!steady) begin
         while ($urandom_range(99) < 8) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_raw_pixel   <= pix;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // let every expected item arrive and the pipeline empty out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [LINE_WIDTH_BITS-1:0] width,
                            input logic demosaic, input logic rgb565);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LINE_WIDTH;
      csr_write_data   <= width;
      @(posedge clock);
      csr_index        <= CSR_DEMOSAIC_ENABLE;
      csr_write_data   <= LINE_WIDTH_BITS'(demosaic);
      @(posedge clock);
      csr_index        <= CSR_PACK_RGB565;
      csr_write_data   <= LINE_WIDTH_BITS'(rgb565);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model.write_reg(CSR_LINE_WIDTH, width);
      model.write_reg(CSR_DEMOSAIC_ENABLE, LINE_WIDTH_BITS'(demosaic));
      model.write_reg(CSR_PACK_RGB565, LINE_WIDTH_BITS'(rgb565));
   endtask

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_bayer_demosaic_to_rgb NOT OK");
      $finish;
   end

   initial begin
      int unsigned                sent;
      int unsigned                eff_width;
      int unsigned                count;
      int unsigned                pick;
      logic [LINE_WIDTH_BITS-1:0] width;
      logic                       demosaic;
      logic                       rgb565;
      logic                       fresh;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two rows fill every line store column that later rows can read
      configure(LINE_WIDTH_BITS'(FILL_W), 1'b1, 1'b0);
      for (int i = 0; i < 2 * FILL_W; i++) send_sample(8'($urandom), i == 0);
      settle();

      // width below range acts as two
      configure(13'd1, 1'b1, 1'b0);
      send_sample(8'hFF, 1'b1);
      send_sample(8'h00, 1'b0);
      send_sample(8'hFE, 1'b0);
      send_sample(8'hFF, 1'b0);
      settle();

      // three wide in rgb565: all four window phases
      configure(13'd3, 1'b1, 1'b1);
      for (int i = 0; i < 9; i++)
         send_sample((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h83), i == 0);
      settle();

      // grey replicate, width zero
      configure(13'd0, 1'b0, 1'b1);
      send_sample(8'hFF, 1'b1);
      send_sample(8'h00, 1'b0);
      send_sample(8'h80, 1'b0);
      settle();

      // width shrunk mid-row, then frame start mid-row
      configure(13'd4, 1'b1, 1'b0);
      for (int i = 0; i < 7; i++) send_sample(8'($urandom), i == 0);
      settle();
      configure(13'd2, 1'b1, 1'b0);
      send_sample(8'h00, 1'b0);
      send_sample(8'hFF, 1'b0);
      send_sample(8'h01, 1'b0);
      send_sample(8'hFF, 1'b0);
      send_sample(8'h7F, 1'b1);
      send_sample(8'h80, 1'b0);
      settle();

      sent = 0;
      while (sent < 1600) begin
         pick = $urandom_range(99);
         if (pick < 5) width = LINE_WIDTH_BITS'($urandom_range(1));
         else if (pick < 10) width = LINE_WIDTH_BITS'($urandom_range(8191, 4096));
         else width = LINE_WIDTH_BITS'($urandom_range(16, 2));
         demosaic = $urandom_range(99) < 75;
         rgb565   = $urandom_range(1);
         configure(width, demosaic, rgb565);
         eff_width = (width < MIN_LINE_WIDTH) ? MIN_LINE_WIDTH : ((width > MAX_W) ? MAX_W : width);
         if (eff_width > 16) count = $urandom_range(40, 1);
         else count = $urandom_range(5, 2) * eff_width + $urandom_range(eff_width - 1);
         // wide rows start a frame so they never read past the filled columns
         fresh = (eff_width > 16) || ($urandom_range(99) < 85);
         steady <= (sent >= 600 && sent < 900);
         for (int i = 0; i < count; i++)
            send_sample(8'($urandom), (i == 0 && fresh) || ($urandom_range(99) < 2));
         sent += count;
         settle();
      end
      steady <= 1'b0;
      settle();

      if (model.errors == 0) begin
         $display("tb_bayer_demosaic_to_rgb OK");
      end else begin
         $display("tb_bayer_demosaic_to_rgb NOT OK");
      end
      $finish;
   end

endmodule
